FILE: rtl/core/sgrad_pkg.sv
package sgrad_pkg;

  // Default depth of the queue between the front and back parts.
  localparam int unsigned QueueDepth = 2;

  // SGR parameter codes and colour constants.
  localparam logic [7:0] CodeReset     = 8'd0;
  localparam logic [7:0] CodeBoldOn    = 8'd1;
  localparam logic [7:0] CodeFaint     = 8'd2;
  localparam logic [7:0] CodeItalicOn  = 8'd3;
  localparam logic [7:0] CodeUnderOn   = 8'd4;
  localparam logic [7:0] CodeColorSel  = 8'd5;
  localparam logic [7:0] CodeNormal    = 8'd22;
  localparam logic [7:0] CodeItalicOff = 8'd23;
  localparam logic [7:0] CodeUnderOff  = 8'd24;
  localparam logic [7:0] CodeFgBase    = 8'd30;
  localparam logic [7:0] CodeFgLast    = 8'd37;
  localparam logic [7:0] CodeFgExt     = 8'd38;
  localparam logic [7:0] CodeBgDefault = 8'd39;
  localparam logic [7:0] CodeBgBase    = 8'd40;
  localparam logic [7:0] CodeBgLast    = 8'd47;
  localparam logic [7:0] CodeBgExt     = 8'd48;
  localparam logic [7:0] CubeBase      = 8'd16;
  localparam logic [7:0] GreyBase      = 8'd232;
  localparam logic [7:0] CubeStep      = 8'd42;
  localparam logic [7:0] GreyStep      = 8'd10;
  localparam logic [7:0] CubeSide      = 8'd6;
  localparam logic [7:0] CubePlane     = 8'd36;

  typedef enum logic [1:0] {
    KIND_DEFAULT = 2'd0,
    KIND_PALETTE = 2'd1,
    KIND_RGB     = 2'd2
  } kind_e;

  // Plain decode operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RESET,
    OP_BOLD_ON,
    OP_BOLD_OFF,
    OP_ITALIC_ON,
    OP_ITALIC_OFF,
    OP_UNDER_ON,
    OP_UNDER_OFF,
    OP_FG_PAL,
    OP_BG_DEFAULT,
    OP_BG_PAL
  } op_e;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    op_e         op;
    logic [2:0]  pal;
    logic        fg_ext;
    logic        bg_ext;
    logic        color_sel;
    logic        low;
    logic [23:0] rgb;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Full attribute set of one result.
  typedef struct packed {
    logic [1:0]  fg_kind;
    logic [2:0]  fg_index;
    logic [23:0] fg_rgb;
    logic        light_kind;
    logic [2:0]  light_index;
    logic [1:0]  bg_kind;
    logic [2:0]  bg_index;
    logic [23:0] bg_rgb;
    logic        bold_on;
    logic        italic_on;
    logic        underline_on;
  } attr_t;

  // Extended colour number to RGB: cube for 16..231, grey ramp above.
  // Divisions by 36 and 6 go through reciprocal multiplies, exact on 0..215.
  function automatic logic [23:0] colour_of(logic [7:0] c);
    logic [7:0]  t;
    logic [13:0] qm;
    logic [2:0]  q;
    logic [7:0]  rem8;
    logic [5:0]  rem;
    logic [11:0] gm;
    logic [2:0]  g;
    logic [5:0]  b6;
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [7:0]  v;
    t    = c - CubeBase;
    qm   = 14'(t) * 14'd57;
    q    = qm[13:11];
    rem8 = t - 8'(8'(q) * CubePlane);
    rem  = rem8[5:0];
    gm   = 12'(rem) * 12'd43;
    g    = gm[10:8];
    b6   = rem - 6'(6'(g) * 6'(CubeSide));
    r8   = 8'(8'(q) * CubeStep);
    g8   = 8'(8'(g) * CubeStep);
    b8   = 8'(8'(b6[2:0]) * CubeStep);
    v    = 8'((c - GreyBase) * GreyStep);
    if (c < GreyBase) begin
      colour_of = {r8, g8, b8};
    end else begin
      colour_of = {v, v, v};
    end
  endfunction

endpackage

FILE: rtl/core/sgrad_if.sv
interface sgrad_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code;

  modport source (output valid, output code, input ready);
  modport sink (input valid, input code, output ready);
endinterface

interface sgrad_attr_if;
  logic        valid;
  logic        ready;
  logic [1:0]  fg_kind;
  logic [2:0]  fg_index;
  logic [23:0] fg_rgb;
  logic        light_kind;
  logic [2:0]  light_index;
  logic [1:0]  bg_kind;
  logic [2:0]  bg_index;
  logic [23:0] bg_rgb;
  logic        bold_on;
  logic        italic_on;
  logic        underline_on;

  modport source (
    output valid, output fg_kind, output fg_index, output fg_rgb,
    output light_kind, output light_index, output bg_kind, output bg_index,
    output bg_rgb, output bold_on, output italic_on, output underline_on,
    input ready
  );
  modport sink (
    input valid, input fg_kind, input fg_index, input fg_rgb,
    input light_kind, input light_index, input bg_kind, input bg_index,
    input bg_rgb, input bold_on, input italic_on, input underline_on,
    output ready
  );
endinterface

FILE: rtl/core/sgrad_front.sv
module sgrad_front (
  sgrad_code_if.sink         code_i,
  input  sgrad_pkg::q_stat_t q_stat_i,
  output logic               push_o,
  output sgrad_pkg::cmd_t    cmd_o
);

  logic [7:0] c;

  assign c             = code_i.code;
  assign code_i.ready  = !q_stat_i.full;
  assign push_o        = code_i.valid && !q_stat_i.full;

  always_comb begin
    cmd_o.op  = sgrad_pkg::OP_NONE;
    cmd_o.pal = '0;
    if (c == sgrad_pkg::CodeReset) begin
      cmd_o.op = sgrad_pkg::OP_RESET;
    end else if (c == sgrad_pkg::CodeBoldOn) begin
      cmd_o.op = sgrad_pkg::OP_BOLD_ON;
    end else if (c == sgrad_pkg::CodeFaint || c == sgrad_pkg::CodeNormal) begin
      cmd_o.op = sgrad_pkg::OP_BOLD_OFF;
    end else if (c == sgrad_pkg::CodeItalicOn) begin
      cmd_o.op = sgrad_pkg::OP_ITALIC_ON;
    end else if (c == sgrad_pkg::CodeItalicOff) begin
      cmd_o.op = sgrad_pkg::OP_ITALIC_OFF;
    end else if (c == sgrad_pkg::CodeUnderOn) begin
      cmd_o.op = sgrad_pkg::OP_UNDER_ON;
    end else if (c == sgrad_pkg::CodeUnderOff) begin
      cmd_o.op = sgrad_pkg::OP_UNDER_OFF;
    end else if (c >= sgrad_pkg::CodeFgBase && c <= sgrad_pkg::CodeFgLast) begin
      cmd_o.op  = sgrad_pkg::OP_FG_PAL;
      cmd_o.pal = 3'(c - sgrad_pkg::CodeFgBase);
    end else if (c == sgrad_pkg::CodeBgDefault) begin
      cmd_o.op = sgrad_pkg::OP_BG_DEFAULT;
    end else if (c >= sgrad_pkg::CodeBgBase && c <= sgrad_pkg::CodeBgLast) begin
      cmd_o.op  = sgrad_pkg::OP_BG_PAL;
      cmd_o.pal = 3'(c - sgrad_pkg::CodeBgBase);
    end
    cmd_o.fg_ext    = (c == sgrad_pkg::CodeFgExt);
    cmd_o.bg_ext    = (c == sgrad_pkg::CodeBgExt);
    cmd_o.color_sel = (c == sgrad_pkg::CodeColorSel);
    cmd_o.low       = (c < sgrad_pkg::CubeBase);
    cmd_o.rgb       = sgrad_pkg::colour_of(c);
  end

endmodule

FILE: rtl/core/sgrad_queue.sv
module sgrad_queue #(
  parameter int unsigned Depth = sgrad_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sgrad_pkg::cmd_t    cmd_i,
  input  logic               pop_i,
  output sgrad_pkg::cmd_t    cmd_o,
  output sgrad_pkg::q_stat_t q_stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sgrad_pkg::cmd_t slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign q_stat_o.full  = (count_q == CntW'(Depth));
  assign q_stat_o.empty = (count_q == '0);
  assign cmd_o          = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/core/sgrad_back.sv
module sgrad_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sgrad_pkg::cmd_t    cmd_i,
  input  sgrad_pkg::q_stat_t q_stat_i,
  output logic               pop_o,
  sgrad_attr_if.source       attr_o
);

  logic                ext_q, ext_d;
  logic                fgp_q, fgp_d;
  logic                bgp_q, bgp_d;
  logic                await_q, await_d;
  sgrad_pkg::kind_e    fg_sel_q, fg_sel_d;
  logic [2:0]          fg_pal_q, fg_pal_d;
  logic [23:0]         fg_rgb_q, fg_rgb_d;
  logic                light_sel_q, light_sel_d;
  logic [2:0]          light_pal_q, light_pal_d;
  sgrad_pkg::kind_e    bg_sel_q, bg_sel_d;
  logic [2:0]          bg_pal_q, bg_pal_d;
  logic [23:0]         bg_rgb_q, bg_rgb_d;
  logic                bold_q, bold_d;
  logic                italic_q, italic_d;
  logic                under_q, under_d;
  logic                do_plain;
  logic                ext_now;
  logic                out_valid_q, out_valid_d;
  sgrad_pkg::attr_t    out_d, out_q;

  // Pop whenever the output register is free or being drained.
  assign pop_o = !q_stat_i.empty && (!out_valid_q || attr_o.ready);
  assign ext_now = ext_q || cmd_i.bg_ext;

  always_comb begin
    ext_d       = ext_q;
    fgp_d       = fgp_q;
    bgp_d       = bgp_q;
    await_d     = await_q;
    fg_sel_d    = fg_sel_q;
    fg_pal_d    = fg_pal_q;
    fg_rgb_d    = fg_rgb_q;
    light_sel_d = light_sel_q;
    light_pal_d = light_pal_q;
    bg_sel_d    = bg_sel_q;
    bg_pal_d    = bg_pal_q;
    bg_rgb_d    = bg_rgb_q;
    bold_d      = bold_q;
    italic_d    = italic_q;
    under_d     = under_q;
    do_plain    = 1'b0;

    // Armed colour: serve the foreground request first.
    if (await_q && fgp_q) begin
      fgp_d   = 1'b0;
      await_d = 1'b0;
      ext_d   = 1'b0;
      if (cmd_i.low) begin
        do_plain = 1'b1;
      end else begin
        fg_sel_d = sgrad_pkg::KIND_RGB;
        fg_rgb_d = cmd_i.rgb;
      end
    end else if (await_q && bgp_q) begin
      bgp_d   = 1'b0;
      await_d = 1'b0;
      ext_d   = 1'b0;
      if (cmd_i.low) begin
        do_plain = 1'b1;
      end else begin
        bg_sel_d = sgrad_pkg::KIND_RGB;
        bg_rgb_d = cmd_i.rgb;
      end
    end else if (cmd_i.fg_ext) begin
      ext_d = 1'b1;
      fgp_d = 1'b1;
    end else begin
      if (cmd_i.bg_ext) begin
        ext_d = 1'b1;
        bgp_d = 1'b1;
      end
      if (ext_now && cmd_i.color_sel) begin
        await_d = 1'b1;
      end else begin
        do_plain = 1'b1;
      end
    end

    if (do_plain) begin
      unique case (cmd_i.op)
        sgrad_pkg::OP_RESET: begin
          ext_d       = 1'b0;
          fgp_d       = 1'b0;
          bgp_d       = 1'b0;
          await_d     = 1'b0;
          fg_sel_d    = sgrad_pkg::KIND_DEFAULT;
          fg_pal_d    = '0;
          fg_rgb_d    = '0;
          light_sel_d = 1'b0;
          light_pal_d = '0;
          bg_sel_d    = sgrad_pkg::KIND_DEFAULT;
          bg_pal_d    = '0;
          bg_rgb_d    = '0;
          bold_d      = 1'b0;
          italic_d    = 1'b0;
          under_d     = 1'b0;
        end
        sgrad_pkg::OP_BOLD_ON:     bold_d   = 1'b1;
        sgrad_pkg::OP_BOLD_OFF:    bold_d   = 1'b0;
        sgrad_pkg::OP_ITALIC_ON:   italic_d = 1'b1;
        sgrad_pkg::OP_ITALIC_OFF:  italic_d = 1'b0;
        sgrad_pkg::OP_UNDER_ON:    under_d  = 1'b1;
        sgrad_pkg::OP_UNDER_OFF:   under_d  = 1'b0;
        sgrad_pkg::OP_FG_PAL: begin
          fg_sel_d    = sgrad_pkg::KIND_PALETTE;
          fg_pal_d    = cmd_i.pal;
          light_sel_d = 1'b1;
          light_pal_d = cmd_i.pal;
        end
        sgrad_pkg::OP_BG_DEFAULT:  bg_sel_d = sgrad_pkg::KIND_DEFAULT;
        sgrad_pkg::OP_BG_PAL: begin
          bg_sel_d = sgrad_pkg::KIND_PALETTE;
          bg_pal_d = cmd_i.pal;
        end
        default: ;
      endcase
    end
  end

  // Result fields show palette and rgb values only for the matching kind.
  always_comb begin
    out_d.fg_kind      = fg_sel_d;
    out_d.fg_index     = (fg_sel_d == sgrad_pkg::KIND_PALETTE) ? fg_pal_d : '0;
    out_d.fg_rgb       = (fg_sel_d == sgrad_pkg::KIND_RGB) ? fg_rgb_d : '0;
    out_d.light_kind   = light_sel_d;
    out_d.light_index  = light_sel_d ? light_pal_d : '0;
    out_d.bg_kind      = bg_sel_d;
    out_d.bg_index     = (bg_sel_d == sgrad_pkg::KIND_PALETTE) ? bg_pal_d : '0;
    out_d.bg_rgb       = (bg_sel_d == sgrad_pkg::KIND_RGB) ? bg_rgb_d : '0;
    out_d.bold_on      = bold_d;
    out_d.italic_on    = italic_d;
    out_d.underline_on = under_d;
  end

  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (attr_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q       <= 1'b0;
      fgp_q       <= 1'b0;
      bgp_q       <= 1'b0;
      await_q     <= 1'b0;
      fg_sel_q    <= sgrad_pkg::KIND_DEFAULT;
      fg_pal_q    <= '0;
      fg_rgb_q    <= '0;
      light_sel_q <= 1'b0;
      light_pal_q <= '0;
      bg_sel_q    <= sgrad_pkg::KIND_DEFAULT;
      bg_pal_q    <= '0;
      bg_rgb_q    <= '0;
      bold_q      <= 1'b0;
      italic_q    <= 1'b0;
      under_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        ext_q       <= ext_d;
        fgp_q       <= fgp_d;
        bgp_q       <= bgp_d;
        await_q     <= await_d;
        fg_sel_q    <= fg_sel_d;
        fg_pal_q    <= fg_pal_d;
        fg_rgb_q    <= fg_rgb_d;
        light_sel_q <= light_sel_d;
        light_pal_q <= light_pal_d;
        bg_sel_q    <= bg_sel_d;
        bg_pal_q    <= bg_pal_d;
        bg_rgb_q    <= bg_rgb_d;
        bold_q      <= bold_d;
        italic_q    <= italic_d;
        under_q     <= under_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign attr_o.valid        = out_valid_q;
  assign attr_o.fg_kind      = out_q.fg_kind;
  assign attr_o.fg_index     = out_q.fg_index;
  assign attr_o.fg_rgb       = out_q.fg_rgb;
  assign attr_o.light_kind   = out_q.light_kind;
  assign attr_o.light_index  = out_q.light_index;
  assign attr_o.bg_kind      = out_q.bg_kind;
  assign attr_o.bg_index     = out_q.bg_index;
  assign attr_o.bg_rgb       = out_q.bg_rgb;
  assign attr_o.bold_on      = out_q.bold_on;
  assign attr_o.italic_on    = out_q.italic_on;
  assign attr_o.underline_on = out_q.underline_on;

endmodule

FILE: rtl/core/sgr_attribute_decoder_top.sv
// Channel   Dir  Payload                                          Accepted when
// code_i    in   code[7:0]                                        valid && ready
// attr_o    out  fg/light/bg kind, index, rgb; bold/italic/under  valid && ready
//
// One code per cycle sustained while attr_o keeps up. The front classifies a
// code and writes it into the queue at its accepting edge; the back applies it
// and loads the output register when it pops the head, which waits while a
// result is held on attr_o. The queue (QueueDepth entries) lets the front
// keep taking codes while a finished result waits on attr_o; once it is full,
// input stalls until the head drains. Reset clears all attributes, the
// extended-colour flags, the queue and the output valid.
module sgr_attribute_decoder_top #(
  parameter int unsigned QueueDepth = sgrad_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sgrad_code_if.sink   code_i,
  sgrad_attr_if.source attr_o
);

  sgrad_pkg::q_stat_t q_stat;
  sgrad_pkg::cmd_t    push_cmd;
  sgrad_pkg::cmd_t    head_cmd;
  logic               push;
  logic               pop;

  // Front: take a request and classify the code; the cube and grey colour is
  // resolved here so the back part only selects.
  sgrad_front u_front (
    .code_i   (code_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // Short queue between front and back; each side stalls on its own.
  sgrad_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .q_stat_o (q_stat)
  );

  // Back: apply the request to the attribute state and register the result.
  sgrad_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (head_cmd),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .attr_o   (attr_o)
  );

  // A direct foreground colour never carries a palette index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    attr_o.valid && attr_o.fg_kind == sgrad_pkg::KIND_RGB |-> attr_o.fg_index == 3'd0)
  else $error("fg palette index leaks into direct colour result");

  // A background that is not direct (palette or default) never carries a direct colour.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    attr_o.valid && attr_o.bg_kind != sgrad_pkg::KIND_RGB |-> attr_o.bg_rgb == 24'd0)
  else $error("bg rgb leaks into non-direct result");

  // A request taken into an empty queue with a free output passes the queue
  // slot and the output register with no stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && q_stat.empty && (!attr_o.valid || attr_o.ready) |-> ##2 attr_o.valid)
  else $error("request lost between queue and output register");

  // The queue is never full and empty at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
  else $error("queue status inconsistent");

endmodule

FILE: bench/sgrad_attr_checker.sv
`timescale 1ns / 1ps

module sgrad_attr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  sgrad_code_if       code_i,
  sgrad_attr_if       attr_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned ReportCap = 200;

  // Predicted decoder state.
  logic               ext_armed;
  logic               fg_req;
  logic               bg_req;
  logic               colour_due;
  sgrad_pkg::kind_e   fg_sel;
  logic [2:0]         fg_pal;
  logic [23:0]        fg_rgb;
  logic               light_sel;
  logic [2:0]         light_pal;
  sgrad_pkg::kind_e   bg_sel;
  logic [2:0]         bg_pal;
  logic [23:0]        bg_rgb;
  logic               bold_q;
  logic               italic_q;
  logic               under_q;

  sgrad_pkg::attr_t   attrs_due[$];
  int unsigned        mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic clear_state();
    ext_armed  = 1'b0;
    fg_req     = 1'b0;
    bg_req     = 1'b0;
    colour_due = 1'b0;
    fg_sel     = sgrad_pkg::KIND_DEFAULT;
    fg_pal     = '0;
    fg_rgb     = '0;
    light_sel  = 1'b0;
    light_pal  = '0;
    bg_sel     = sgrad_pkg::KIND_DEFAULT;
    bg_pal     = '0;
    bg_rgb     = '0;
    bold_q     = 1'b0;
    italic_q   = 1'b0;
    under_q    = 1'b0;
  endtask

  // Colour number 16..255 to rgb: 6x6x6 cube, then the grey ramp.
  function automatic logic [23:0] cube_grey_rgb(logic [7:0] c);
    int unsigned idx;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    int unsigned v;
    if (c < sgrad_pkg::GreyBase) begin
      idx = int'(c) - int'(sgrad_pkg::CubeBase);
      r   = (idx / sgrad_pkg::CubePlane) * sgrad_pkg::CubeStep;
      g   = ((idx % sgrad_pkg::CubePlane) / sgrad_pkg::CubeSide) * sgrad_pkg::CubeStep;
      b   = (idx % sgrad_pkg::CubeSide) * sgrad_pkg::CubeStep;
      return {r[7:0], g[7:0], b[7:0]};
    end
    v = (int'(c) - int'(sgrad_pkg::GreyBase)) * sgrad_pkg::GreyStep;
    return {v[7:0], v[7:0], v[7:0]};
  endfunction

  task automatic plain_update(logic [7:0] c);
    if (c == sgrad_pkg::CodeReset) begin
      clear_state();
    end else if (c == sgrad_pkg::CodeBoldOn) begin
      bold_q = 1'b1;
    end else if (c == sgrad_pkg::CodeFaint || c == sgrad_pkg::CodeNormal) begin
      bold_q = 1'b0;
    end else if (c == sgrad_pkg::CodeItalicOn) begin
      italic_q = 1'b1;
    end else if (c == sgrad_pkg::CodeItalicOff) begin
      italic_q = 1'b0;
    end else if (c == sgrad_pkg::CodeUnderOn) begin
      under_q = 1'b1;
    end else if (c == sgrad_pkg::CodeUnderOff) begin
      under_q = 1'b0;
    end else if (c >= sgrad_pkg::CodeFgBase && c <= sgrad_pkg::CodeFgLast) begin
      fg_sel    = sgrad_pkg::KIND_PALETTE;
      fg_pal    = 3'(c - sgrad_pkg::CodeFgBase);
      light_sel = 1'b1;
      light_pal = 3'(c - sgrad_pkg::CodeFgBase);
    end else if (c == sgrad_pkg::CodeBgDefault) begin
      bg_sel = sgrad_pkg::KIND_DEFAULT;
    end else if (c >= sgrad_pkg::CodeBgBase && c <= sgrad_pkg::CodeBgLast) begin
      bg_sel = sgrad_pkg::KIND_PALETTE;
      bg_pal = 3'(c - sgrad_pkg::CodeBgBase);
    end
  endtask

  task automatic apply_code(logic [7:0] c);
    logic served;
    served = 1'b0;
    // An armed colour goes to the foreground first, then the background.
    if (colour_due && fg_req) begin
      fg_req     = 1'b0;
      colour_due = 1'b0;
      ext_armed  = 1'b0;
      served     = 1'b1;
      if (c < sgrad_pkg::CubeBase) begin
        plain_update(c);
      end else begin
        fg_sel = sgrad_pkg::KIND_RGB;
        fg_rgb = cube_grey_rgb(c);
      end
    end else if (colour_due && bg_req) begin
      bg_req     = 1'b0;
      colour_due = 1'b0;
      ext_armed  = 1'b0;
      served     = 1'b1;
      if (c < sgrad_pkg::CubeBase) begin
        plain_update(c);
      end else begin
        bg_sel = sgrad_pkg::KIND_RGB;
        bg_rgb = cube_grey_rgb(c);
      end
    end
    if (!served) begin
      if (c == sgrad_pkg::CodeFgExt) begin
        ext_armed = 1'b1;
        fg_req    = 1'b1;
      end else begin
        if (c == sgrad_pkg::CodeBgExt) begin
          ext_armed = 1'b1;
          bg_req    = 1'b1;
        end
        if (ext_armed && c == sgrad_pkg::CodeColorSel) begin
          colour_due = 1'b1;
        end else begin
          plain_update(c);
        end
      end
    end
  endtask

  function automatic sgrad_pkg::attr_t current_attrs();
    sgrad_pkg::attr_t a;
    a.fg_kind      = fg_sel;
    a.fg_index     = (fg_sel == sgrad_pkg::KIND_PALETTE) ? fg_pal : 3'd0;
    a.fg_rgb       = (fg_sel == sgrad_pkg::KIND_RGB) ? fg_rgb : 24'd0;
    a.light_kind   = light_sel;
    a.light_index  = light_sel ? light_pal : 3'd0;
    a.bg_kind      = bg_sel;
    a.bg_index     = (bg_sel == sgrad_pkg::KIND_PALETTE) ? bg_pal : 3'd0;
    a.bg_rgb       = (bg_sel == sgrad_pkg::KIND_RGB) ? bg_rgb : 24'd0;
    a.bold_on      = bold_q;
    a.italic_on    = italic_q;
    a.underline_on = under_q;
    return a;
  endfunction

  task automatic note_failure(input string what, input logic [23:0] want,
                              input logic [23:0] got);
    mismatches++;
    if (mismatches <= ReportCap) begin
      $display("%0t: %s expected 'h%0h actual 'h%0h", $time, what, want, got);
    end
  endtask

  task automatic check_field(input string what, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      note_failure(what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sgrad_pkg::attr_t want;
    if (!rst_ni) begin
      clear_state();
      attrs_due.delete();
    end else begin
      if (code_i.valid && code_i.ready) begin
        apply_code(code_i.code);
        attrs_due.push_back(current_attrs());
      end
      if (attr_i.valid && attr_i.ready) begin
        if (attrs_due.size() == 0) begin
          note_failure("unexpected result fg_rgb", 24'd0, attr_i.fg_rgb);
        end else begin
          want = attrs_due.pop_front();
          check_field("fg_kind", want.fg_kind, attr_i.fg_kind);
          check_field("fg_index", want.fg_index, attr_i.fg_index);
          check_field("fg_rgb", want.fg_rgb, attr_i.fg_rgb);
          check_field("light_kind", want.light_kind, attr_i.light_kind);
          check_field("light_index", want.light_index, attr_i.light_index);
          check_field("bg_kind", want.bg_kind, attr_i.bg_kind);
          check_field("bg_index", want.bg_index, attr_i.bg_index);
          check_field("bg_rgb", want.bg_rgb, attr_i.bg_rgb);
          check_field("bold_on", want.bold_on, attr_i.bold_on);
          check_field("italic_on", want.italic_on, attr_i.italic_on);
          check_field("underline_on", want.underline_on, attr_i.underline_on);
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= attrs_due.size();
  end

endmodule

FILE: bench/tb_sgr_attribute_decoder_top.sv
`timescale 1ns / 1ps

module tb_sgr_attribute_decoder_top;

  localparam int unsigned RandomItems = 1800;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned MaxGap      = 8;
  localparam int unsigned MaxBurst    = 40;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_BEAT
  } sink_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sgrad_code_if code_if ();
  sgrad_attr_if attr_if ();

  int unsigned fail_count;
  int unsigned pending;

  sgr_attribute_decoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .code_i (code_if),
    .attr_o (attr_if)
  );

  // The checker watches both channels, predicts every result and compares.
  sgrad_attr_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .code_i       (code_if),
    .attr_i       (attr_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop: far beyond the slowest correct run, even with long stalls.
  initial begin
    #5_000_000;
    $display("tb_sgr_attribute_decoder_top: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: switch at random among the stall patterns; the open pattern
  // gives stretches with no back-pressure at all.
  // ---------------------------------------------------------------------------
  sink_mode_e  sink_mode = SINK_OPEN;
  int unsigned mode_left = 0;
  int unsigned sink_tick = 0;

  always @(posedge clk_i) begin
    sink_tick <= sink_tick + 1;
    if (mode_left == 0) begin
      sink_mode <= sink_mode_e'($urandom_range(3, 0));
      mode_left <= $urandom_range(200, 20);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:   attr_if.ready <= 1'b1;
      SINK_COIN:   attr_if.ready <= 1'($urandom_range(1, 0));
      SINK_SPARSE: attr_if.ready <= ($urandom_range(3, 0) == 0);
      default:     attr_if.ready <= sink_tick[1];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender: requests go out in bursts; between bursts hold valid low for a
  // random gap and scramble the code bus so idle data never leaks through.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  task automatic send_code(input logic [7:0] c);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(MaxBurst, 1);
      gap        = $urandom_range(MaxGap, 1);
      code_if.valid <= 1'b0;
      code_if.code  <= 8'($urandom_range(255, 0));
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    code_if.valid <= 1'b1;
    code_if.code  <= c;
    // Advance until the request is taken.
    @(posedge clk_i);
    while (!code_if.ready) @(posedge clk_i);
  endtask

  // Pick a plain code; a full reset stays rare so attributes pile up.
  function automatic logic [7:0] plain_pick();
    int unsigned sel;
    sel = $urandom_range(31, 0);
    case (sel)
      0:       return sgrad_pkg::CodeReset;
      1, 2:    return sgrad_pkg::CodeBoldOn;
      3:       return sgrad_pkg::CodeFaint;
      4:       return sgrad_pkg::CodeNormal;
      5, 6:    return sgrad_pkg::CodeItalicOn;
      7:       return sgrad_pkg::CodeItalicOff;
      8, 9:    return sgrad_pkg::CodeUnderOn;
      10:      return sgrad_pkg::CodeUnderOff;
      11, 12:  return sgrad_pkg::CodeBgDefault;
      13, 14:  return sgrad_pkg::CodeColorSel;
      15, 16, 17, 18, 19, 20, 21, 22:
        return 8'(sgrad_pkg::CodeFgBase + $urandom_range(7, 0));
      default: return 8'(sgrad_pkg::CodeBgBase + $urandom_range(7, 0));
    endcase
  endfunction

  // Colour number: mostly cube or grey, sometimes below the cube base.
  function automatic logic [7:0] colour_pick();
    if ($urandom_range(9, 0) < 7) begin
      return 8'($urandom_range(255, sgrad_pkg::CubeBase));
    end
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic logic [7:0] prefix_pick();
    return ($urandom_range(1, 0) != 0) ? sgrad_pkg::CodeFgExt : sgrad_pkg::CodeBgExt;
  endfunction

  int unsigned items_sent;
  int unsigned pick;

  initial begin
    code_if.valid = 1'b0;
    code_if.code  = '0;
    attr_if.ready = 1'b0;
    items_sent    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- Directed part ----------------------------------------------------
    // Plain attributes and palette extremes.
    send_code(sgrad_pkg::CodeBoldOn);
    send_code(sgrad_pkg::CodeItalicOn);
    send_code(sgrad_pkg::CodeUnderOn);
    send_code(sgrad_pkg::CodeFgLast);
    send_code(sgrad_pkg::CodeBgLast);
    // Foreground cube at its first entry, background grey at its last.
    send_code(sgrad_pkg::CodeFgExt);
    send_code(sgrad_pkg::CodeColorSel);
    send_code(sgrad_pkg::CubeBase);
    send_code(sgrad_pkg::CodeBgExt);
    send_code(sgrad_pkg::CodeColorSel);
    send_code(8'd255);
    // Both prefixes armed: foreground served, background left pending.
    send_code(sgrad_pkg::CodeFgExt);
    send_code(sgrad_pkg::CodeBgExt);
    send_code(sgrad_pkg::CodeColorSel);
    send_code(8'd231);
    // Select code outside extended mode does nothing.
    send_code(sgrad_pkg::CodeColorSel);
    // Prefix, then an unrelated code, then the select still arms.
    send_code(sgrad_pkg::CodeFgExt);
    send_code(sgrad_pkg::CodeUnderOff);
    send_code(sgrad_pkg::CodeColorSel);
    send_code(sgrad_pkg::GreyBase);
    // Armed colour below the cube base drops to the plain decode.
    send_code(sgrad_pkg::CodeBgExt);
    send_code(sgrad_pkg::CodeColorSel);
    send_code(sgrad_pkg::CodeItalicOn);
    send_code(sgrad_pkg::CodeFaint);
    send_code(sgrad_pkg::CodeNormal);
    send_code(sgrad_pkg::CodeItalicOff);
    send_code(sgrad_pkg::CodeBgDefault);
    send_code(sgrad_pkg::CodeReset);

    // --- Random part ------------------------------------------------------
    // Half well-formed extended-colour sequences with random content,
    // mixed with plain codes, raw bytes and broken sequences.
    while (items_sent < RandomItems) begin
      pick = $urandom_range(99, 0);
      if (pick < 50) begin
        if ($urandom_range(9, 0) == 0) begin
          send_code(sgrad_pkg::CodeFgExt);
          send_code(sgrad_pkg::CodeBgExt);
          items_sent += 2;
        end else begin
          send_code(prefix_pick());
          items_sent++;
        end
        send_code(sgrad_pkg::CodeColorSel);
        send_code(colour_pick());
        items_sent += 2;
      end else if (pick < 80) begin
        send_code(plain_pick());
        items_sent++;
      end else if (pick < 92) begin
        send_code(8'($urandom_range(255, 0)));
        items_sent++;
      end else begin
        // Broken: a prefix followed by something else, maybe armed later.
        send_code(prefix_pick());
        send_code(($urandom_range(1, 0) != 0) ? plain_pick()
                                               : 8'($urandom_range(255, 0)));
        items_sent += 2;
        if ($urandom_range(1, 0) != 0) begin
          send_code(sgrad_pkg::CodeColorSel);
          send_code(colour_pick());
          items_sent += 2;
        end
      end
    end

    // --- Drain ------------------------------------------------------------
    // Drop valid, let the last request register, then wait for every
    // predicted result and a short tail for strays.
    code_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("tb_sgr_attribute_decoder_top: PASS");
    end else begin
      $display("tb_sgr_attribute_decoder_top: FAIL");
    end
    $finish;
  end

endmodule
